FILE: sv/mfb_pkg.sv
package mfb_pkg;

  // Operation codes carried in the func field.
  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_FILL   = 3'd1;
  localparam logic [2:0] FUNC_PIXEL  = 3'd2;
  localparam logic [2:0] FUNC_BITMAP = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  // Colour codes. Any other code leaves a pixel as it is.
  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_BLACK = 2'd1;

  localparam logic [7:0] BYTE_MSB  = 8'h80;
  localparam logic [7:0] BYTE_ONES = 8'hff;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [3:0] MAX_BITS  = 4'd8;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ_CAP,
    ST_RESULT
  } state_t;

endpackage

FILE: sv/mfb_ifs.sv
interface mfb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [1:0] color;
  logic [7:0] pattern;
  logic [3:0] bit_count;
  logic [8:0] read_index;

  modport source (
    output valid, func, x_pos, y_pos, color, pattern, bit_count, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, x_pos, y_pos, color, pattern, bit_count, read_index,
    output ready
  );
endinterface

interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] clipped_count;

  modport source (
    output valid, read_data, clipped_count,
    input  ready
  );
  modport sink (
    input  valid, read_data, clipped_count,
    output ready
  );
endinterface

FILE: sv/mfb_ram.sv
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mono_framebuffer_pixel_blit.sv
// Monochrome page-organised frame store. Pixel (x, y) lives in byte
// x + (y / 8) * SCREEN_WIDTH at bit y mod 8, and the store is one block RAM
// of STORE_BYTES bytes with a registered read port. Each beat on the input
// channel is one operation and gives exactly one result beat: clear, fill,
// set one pixel, draw one bitmap byte (MSB first, one column per bit from
// x_pos, only set bits drawn) or read one byte. Black sets a bit, white
// clears it and the other two colour codes leave it alone; pixels that fall
// off the screen or past the end of the store are skipped and counted in
// clipped_count. Timing: the block takes one operation at a time and is not
// ready while it works. The result beat is raised in the same cycle as the
// input is ready again. Drawing walks the bitmap bits one per cycle through
// a single column counter and address adder, and stops for a
// read-modify-write through the RAM at every on-screen drawn pixel in black
// or white. Clear and fill write one byte a cycle. After reset a clearing
// pass writes zero to every byte of the store before the first beat is
// accepted. A finished result sits in an output register, so the next
// beat may be taken while the previous result is still waiting on the
// output side.
module mono_framebuffer_pixel_blit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32,
  parameter int STORE_BYTES   = 512
) (
  input  logic  clk,
  input  logic  rst_n,
  mfb_in_if.sink    in_ch,
  mfb_out_if.source out_ch
);

  import mfb_pkg::*;

  // Number of pages (eight-row bands) and the widths that follow from them.
  localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
  localparam int IDX_W  = $clog2(PAGES * SCREEN_WIDTH + 1);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int CMP_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
  localparam int RCMP_W = ((ADDR_W > 9) ? ADDR_W : 9) + 1;

  localparam logic [9:0]        WIDTH_LIM  = 10'(SCREEN_WIDTH);
  localparam logic [8:0]        HEIGHT_LIM = 9'(SCREEN_HEIGHT);
  localparam logic [CMP_W-1:0]  STORE_LIM  = CMP_W'(STORE_BYTES);
  localparam logic [RCMP_W-1:0] READ_LIM   = RCMP_W'(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);
  localparam logic [IDX_W-1:0]  ROW_STRIDE = IDX_W'(SCREEN_WIDTH);

  // Sequencer state.
  state_t state_r, state_nxt;

  // Operation context, loaded when a beat is accepted.
  logic [1:0]        color_r,   color_nxt;
  logic [7:0]        pat_r,     pat_nxt;
  logic [3:0]        rem_r,     rem_nxt;
  logic [8:0]        col_r,     col_nxt;
  logic [IDX_W-1:0]  base_r,    base_nxt;
  logic              row_ok_r,  row_ok_nxt;
  logic [7:0]        mask_r,    mask_nxt;
  logic [ADDR_W-1:0] addr_r,    addr_nxt;
  logic [ADDR_W-1:0] sweep_r,   sweep_nxt;
  logic [7:0]        sweep_v_r, sweep_v_nxt;
  logic [3:0]        clip_r,    clip_nxt;
  logic [7:0]        data_r,    data_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r,  out_data_nxt;
  logic [3:0] out_clip_r,  out_clip_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Shared per-column datapath.
  logic [IDX_W-1:0] pix_idx;
  logic             col_ok;
  logic             idx_ok;
  logic             pix_on;
  logic             pix_paint;
  logic             pix_clip;
  logic             in_acc;
  logic             read_ok;
  logic             out_free;

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign read_ok  = RCMP_W'(in_ch.read_index) < READ_LIM;
  assign out_free = !out_valid_r || out_ch.ready;

  // The one address unit: the current column plus the page base, then the
  // bounds checks. Only meaningful while the column and row are on screen.
  assign pix_idx   = base_r + IDX_W'(col_r);
  assign col_ok    = {1'b0, col_r} < WIDTH_LIM;
  assign idx_ok    = CMP_W'(pix_idx) < STORE_LIM;
  assign pix_on    = row_ok_r && col_ok && idx_ok;
  // A drawn bit is painted only when its colour is black or white.
  assign pix_paint = pat_r[7] && pix_on &&
                     ((color_r == COLOR_WHITE) || (color_r == COLOR_BLACK));
  assign pix_clip  = pat_r[7] && !pix_on;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            FUNC_CLEAR, FUNC_FILL:   state_nxt = ST_SWEEP;
            FUNC_PIXEL, FUNC_BITMAP: state_nxt = ST_PIX_RD;
            FUNC_READ:               state_nxt = read_ok ? ST_READ_CAP : ST_RESULT;
            default:                 state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sweep_r == LAST_ADDR) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_PIX_RD: begin
        if (rem_r == 4'd0) begin
          state_nxt = ST_RESULT;
        end else if (pix_paint) begin
          state_nxt = ST_PIX_WR;
        end
      end
      ST_PIX_WR:   state_nxt = ST_PIX_RD;
      ST_READ_CAP: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    color_nxt     = color_r;
    pat_nxt       = pat_r;
    rem_nxt       = rem_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    row_ok_nxt    = row_ok_r;
    mask_nxt      = mask_r;
    addr_nxt      = addr_r;
    sweep_nxt     = sweep_r;
    sweep_v_nxt   = sweep_v_r;
    clip_nxt      = clip_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_clip_nxt  = out_clip_r;
    ram_we        = 1'b0;
    ram_waddr     = sweep_r;
    ram_wdata     = sweep_v_r;
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(in_ch.read_index);

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_ZERO;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          color_nxt   = in_ch.color;
          col_nxt     = {1'b0, in_ch.x_pos};
          row_ok_nxt  = {1'b0, in_ch.y_pos} < HEIGHT_LIM;
          base_nxt    = IDX_W'(in_ch.y_pos[7:3]) * ROW_STRIDE;
          mask_nxt    = BYTE_ZERO;
          mask_nxt[in_ch.y_pos[2:0]] = 1'b1;
          sweep_nxt   = '0;
          sweep_v_nxt = (in_ch.func == FUNC_FILL) ? BYTE_ONES : BYTE_ZERO;
          clip_nxt    = 4'd0;
          data_nxt    = BYTE_ZERO;
          if (in_ch.func == FUNC_PIXEL) begin
            pat_nxt = BYTE_MSB;
            rem_nxt = 4'd1;
          end else begin
            pat_nxt = in_ch.pattern;
            rem_nxt = (in_ch.bit_count > MAX_BITS) ? MAX_BITS : in_ch.bit_count;
          end
          // A read goes to the RAM straight away; data arrives next cycle.
          ram_re = (in_ch.func == FUNC_READ) && read_ok;
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
        end
      end
      ST_PIX_RD: begin
        if (rem_r != 4'd0) begin
          ram_raddr = ADDR_W'(pix_idx);
          addr_nxt  = ADDR_W'(pix_idx);
          ram_re    = pix_paint;
          if (pix_clip) begin
            clip_nxt = clip_r + 4'd1;
          end
          pat_nxt = {pat_r[6:0], 1'b0};
          col_nxt = col_r + 9'd1;
          rem_nxt = rem_r - 4'd1;
        end
      end
      ST_PIX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = (color_r == COLOR_BLACK) ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
      end
      ST_READ_CAP: begin
        data_nxt = ram_rdata;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_clip_nxt  = clip_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    color_r    <= color_nxt;
    pat_r      <= pat_nxt;
    rem_r      <= rem_nxt;
    col_r      <= col_nxt;
    base_r     <= base_nxt;
    row_ok_r   <= row_ok_nxt;
    mask_r     <= mask_nxt;
    addr_r     <= addr_nxt;
    sweep_v_r  <= sweep_v_nxt;
    clip_r     <= clip_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_data_r;
  assign out_ch.clipped_count = out_clip_r;

  // The write half of a read-modify-write goes back to the byte just read.
  a_rmw_addr : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX_WR) |-> (ram_we && (ram_waddr == $past(ram_raddr))))
    else $error("read-modify-write address mismatch");

  // A new result beat only appears from the result state.
  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESULT))
    else $error("result beat raised outside the result state");

  // No more pixels can be clipped than a bitmap byte holds.
  a_clip_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_clip_r <= MAX_BITS))
    else $error("clipped count out of range");

  // A read within the store is followed by the capture of its data.
  a_read_flow : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.func == FUNC_READ) && read_ok) |=> (state_r == ST_READ_CAP))
    else $error("read did not reach the capture state");

  // The RAM is never written while the block waits for a beat.
  a_idle_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

endmodule

FILE: dv/tb_mono_framebuffer_pixel_blit.sv
`timescale 1ns / 100ps

module tb_mono_framebuffer_pixel_blit;
  import mfb_pkg::*;

  // Geometry of the block under test. The shadow frame store below is laid
  // out the same way: byte x + (y / 8) * SCREEN_W, bit y mod 8.
  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 32;
  localparam int STORE_BYTES = 512;
  localparam int PAGE_ROWS   = 8;

  // Field codes the package does not name. Colours 2 and 3 leave a pixel
  // alone, and function codes above a read do nothing at all.
  localparam logic [1:0] COLOR_KEEP_LO = 2'd2;
  localparam logic [1:0] COLOR_KEEP_HI = 2'd3;
  localparam logic [2:0] FUNC_SPARE_LO = FUNC_READ + 3'd1;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_TARGET = 1875;  // operations after the directed part
  localparam int TAIL_OPS      = 150;   // final stretch with no idling at all
  localparam int LONG_HOLD     = 200;   // receiver hold-off, in cycles
  localparam int NUM_HOLDS     = 2;
  localparam int HOLD_SPACING  = 600;   // beats between receiver hold-offs
  localparam int DRAIN_SPACING = 700;   // operations between sender pauses
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;
  localparam int BITMAP_WORST  = 19;    // eight drawn pixels plus overhead

  // One operation as offered on the input channel. drain_first asks the
  // driver to wait until every outstanding result has come back.
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [1:0] color;
    logic [7:0] pattern;
    logic [3:0] bit_count;
    logic [8:0] read_index;
    logic       drain_first;
  } draw_cmd_t;

  // What one operation hands back.
  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] clipped_count;
  } blit_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  mfb_in_if  in_ch ();
  mfb_out_if out_ch ();

  mono_framebuffer_pixel_blit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .STORE_BYTES  (STORE_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Operations not yet offered, outcomes not yet seen, and the testbench's
  // own copy of the frame store.
  draw_cmd_t     draw_cmds[$];
  blit_outcome_t outcomes_due[$];
  logic [7:0]    shadow_store [STORE_BYTES];

  int          total_ops = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          fault_count = 0;
  int          clip_total = 0;
  int          op_tally [8] = '{default: 0};
  int          hold_left = 0;
  int          holds_done = 0;
  int unsigned worst_cycles = 0;
  int unsigned cycle_limit = 0;
  int unsigned cycle_count = 0;

  draw_cmd_t offered_cmd;
  int        send_gap = 0;
  int        sink_stall = 0;

  // Every fault is counted; only the first few are spelt out so that a
  // badly broken block does not flood the log.
  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("Fault at %0t: %s", $realtime, msg);
    end
  endtask

  // Draws one pixel into the shadow store and returns 1 when it lands off
  // the screen (or past the end of the store) and is therefore clipped.
  // Clipping is counted whatever the colour, even one that changes nothing.
  function automatic logic plot_shadow(int unsigned col, int unsigned row,
                                       logic [1:0] colour);
    int unsigned byte_idx;
    if (col >= SCREEN_W || row >= SCREEN_H) begin
      return 1'b1;
    end
    byte_idx = col + (row / PAGE_ROWS) * SCREEN_W;
    if (byte_idx >= STORE_BYTES) begin
      return 1'b1;
    end
    if (colour == COLOR_BLACK) begin
      shadow_store[byte_idx][row % PAGE_ROWS] = 1'b1;
    end else if (colour == COLOR_WHITE) begin
      shadow_store[byte_idx][row % PAGE_ROWS] = 1'b0;
    end
    return 1'b0;
  endfunction

  // Applies one accepted operation to the shadow store and works out the
  // result beat it must produce.
  function automatic blit_outcome_t render_cmd(draw_cmd_t cmd);
    blit_outcome_t res;
    int unsigned   span;
    res.read_data     = BYTE_ZERO;
    res.clipped_count = '0;
    case (cmd.func)
      FUNC_CLEAR: begin
        foreach (shadow_store[k]) shadow_store[k] = BYTE_ZERO;
      end
      FUNC_FILL: begin
        foreach (shadow_store[k]) shadow_store[k] = BYTE_ONES;
      end
      FUNC_PIXEL: begin
        res.clipped_count = 4'(plot_shadow(cmd.x_pos, cmd.y_pos, cmd.color));
      end
      FUNC_BITMAP: begin
        // Counts above eight are capped. Columns are not wrapped at 255,
        // so a byte drawn near the right-hand end is clipped bit by bit.
        span = (cmd.bit_count > MAX_BITS) ? MAX_BITS : cmd.bit_count;
        for (int i = 0; i < span; i++) begin
          if (((cmd.pattern << i) & BYTE_MSB) != BYTE_ZERO) begin
            res.clipped_count += 4'(plot_shadow(cmd.x_pos + i, cmd.y_pos, cmd.color));
          end
        end
      end
      FUNC_READ: begin
        if (cmd.read_index < STORE_BYTES) begin
          res.read_data = shadow_store[cmd.read_index];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Chance, in percent, that either side starts an idle gap. It moves
  // through calm and busy stretches as the run goes on and drops to zero
  // for the closing part.
  function automatic int idle_pct(int n);
    if (n >= total_ops - TAIL_OPS) begin
      return 0;
    end
    case ((n / 128) % 4)
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 50;
    endcase
  endfunction

  task automatic queue_cmd(input logic [2:0] f, input logic [7:0] col,
                           input logic [7:0] row, input logic [1:0] colour,
                           input logic [7:0] bits, input logic [3:0] nbits,
                           input logic [8:0] idx);
    draw_cmd_t cmd;
    cmd = '{func: f, x_pos: col, y_pos: row, color: colour, pattern: bits,
            bit_count: nbits, read_index: idx, drain_first: 1'b0};
    draw_cmds.push_back(cmd);
    // Budget for the slowest correct handling of this operation: the block's
    // own cycles, a full sender gap and a full receiver stall.
    if (f == FUNC_CLEAR || f == FUNC_FILL) begin
      worst_cycles += STORE_BYTES + 2 + 10;
    end else begin
      worst_cycles += BITMAP_WORST + 10;
    end
  endtask

  // Driver. Offers the queued operations in order, holds each one until it
  // is taken, and predicts the result of every beat at the edge where it is
  // accepted, so the shadow store follows the block's own order of work.
  always @(posedge clk) begin : driver_b
    logic      offer;
    logic      took;
    int        in_now;
    draw_cmd_t nxt;
    if (!rst_n) begin
      // Known values on every input while the block is held in reset.
      in_ch.valid      <= 1'b0;
      in_ch.func       <= FUNC_CLEAR;
      in_ch.x_pos      <= '0;
      in_ch.y_pos      <= '0;
      in_ch.color      <= COLOR_WHITE;
      in_ch.pattern    <= '0;
      in_ch.bit_count  <= '0;
      in_ch.read_index <= '0;
      send_gap = 0;
      foreach (shadow_store[k]) shadow_store[k] = BYTE_ZERO;
    end else begin
      offer = in_ch.valid;
      took  = in_ch.valid && in_ch.ready;
      if (took) begin
        outcomes_due.push_back(render_cmd(offered_cmd));
        op_tally[offered_cmd.func] = op_tally[offered_cmd.func] + 1;
        beats_in <= beats_in + 1;
        offer = 1'b0;
        // No gaps while the receiver is held off: the sender keeps pushing
        // so that the block backs up.
        if (hold_left == 0 && $urandom_range(0, 99) < idle_pct(beats_in)) begin
          send_gap = $urandom_range(1, 4);
        end
      end
      in_now = beats_in + (took ? 1 : 0);
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (draw_cmds.size() != 0 &&
                     !(draw_cmds[0].drain_first && beats_out != in_now)) begin
          nxt = draw_cmds.pop_front();
          offered_cmd = nxt;
          in_ch.func       <= nxt.func;
          in_ch.x_pos      <= nxt.x_pos;
          in_ch.y_pos      <= nxt.y_pos;
          in_ch.color      <= nxt.color;
          in_ch.pattern    <= nxt.pattern;
          in_ch.bit_count  <= nxt.bit_count;
          in_ch.read_index <= nxt.read_index;
          offer = 1'b1;
        end
      end
      // One assignment per edge, so a valid that stays high is never
      // lowered and raised in the same step.
      in_ch.valid <= offer;
    end
  end

  // Long receiver hold-offs, timed in their own process. While one runs the
  // output register fills, the block stops taking beats and the input
  // channel stalls with an item on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < NUM_HOLDS && beats_in >= (holds_done + 1) * HOLD_SPACING) begin
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor. Every result beat is checked field by field against the
  // oldest outstanding prediction; the ready line stalls in short bursts.
  always @(posedge clk) begin : monitor_b
    blit_outcome_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_out <= beats_out + 1;
        clip_total = clip_total + out_ch.clipped_count;
        if (outcomes_due.size() == 0) begin
          log_fault($sformatf("result beat with nothing outstanding (data %0h, clipped %0d)",
                              out_ch.read_data, out_ch.clipped_count));
        end else begin
          want = outcomes_due.pop_front();
          if (out_ch.read_data !== want.read_data) begin
            log_fault($sformatf("result %0d read_data: expected %02h, got %02h",
                                beats_out, want.read_data, out_ch.read_data));
          end
          if (out_ch.clipped_count !== want.clipped_count) begin
            log_fault($sformatf("result %0d clipped_count: expected %0d, got %0d",
                                beats_out, want.clipped_count, out_ch.clipped_count));
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
      end else if ($urandom_range(0, 99) < idle_pct(beats_out)) begin
        sink_stall = $urandom_range(1, 4);
      end
      out_ch.ready <= (sink_stall == 0) && (hold_left == 0);
    end
  end

  // Watchdog against a hung block or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("Timed out after %0d cycles with %0d of %0d beats accepted, %0d results seen.",
               cycle_count, beats_in, total_ops, beats_out);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus_b
    int          roll;
    int          directed_ops;
    logic [2:0]  f;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [1:0]  colour;
    logic [7:0]  bits;
    logic [3:0]  nbits;
    logic [8:0]  idx;
    int unsigned near_idx;

    // Directed part. The store must read back as zero straight after reset.
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd511);
    // Corners of the screen, then the first column and row just past it:
    // those must be clipped, which catches an off-by-one in the bound test.
    queue_cmd(FUNC_PIXEL,  8'd0,   8'd0,   COLOR_BLACK,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_PIXEL,  8'd127, 8'd31,  COLOR_BLACK,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_PIXEL,  8'd128, 8'd0,   COLOR_BLACK,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_PIXEL,  8'd0,   8'd32,  COLOR_BLACK,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_PIXEL,  8'd255, 8'd255, COLOR_WHITE,   8'h00, 4'd0,  9'd0);
    // The two do-nothing colours on pixels that are already set.
    queue_cmd(FUNC_PIXEL,  8'd127, 8'd31,  COLOR_KEEP_LO, 8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_PIXEL,  8'd0,   8'd0,   COLOR_KEEP_HI, 8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd511);
    // Bitmap bytes: half off the right edge, running past column 255 with
    // a count above eight, a count of zero, and sparse patterns in both
    // colours.
    queue_cmd(FUNC_BITMAP, 8'd124, 8'd7,   COLOR_BLACK,   8'hff, 4'd8,  9'd0);
    queue_cmd(FUNC_BITMAP, 8'd250, 8'd3,   COLOR_BLACK,   8'hff, 4'd15, 9'd0);
    queue_cmd(FUNC_BITMAP, 8'd0,   8'd0,   COLOR_BLACK,   8'hff, 4'd0,  9'd0);
    queue_cmd(FUNC_BITMAP, 8'd0,   8'd8,   COLOR_BLACK,   8'ha5, 4'd5,  9'd0);
    queue_cmd(FUNC_BITMAP, 8'd1,   8'd8,   COLOR_WHITE,   8'h40, 4'd2,  9'd0);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd130);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd127);
    // Fill, punch one hole, read it, then clear and read the same byte.
    queue_cmd(FUNC_FILL,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_PIXEL,  8'd3,   8'd17,  COLOR_WHITE,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd259);
    queue_cmd(FUNC_CLEAR,  8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd0);
    queue_cmd(FUNC_READ,   8'd0,   8'd0,   COLOR_WHITE,   8'h00, 4'd0,  9'd259);
    // Unused function codes must leave the store alone and return zeros.
    queue_cmd(FUNC_SPARE_LO, 8'd9, 8'd9,   COLOR_BLACK,   8'hff, 4'd8,  9'd259);
    queue_cmd(FUNC_SPARE_HI, 8'd9, 8'd9,   COLOR_BLACK,   8'hff, 4'd8,  9'd259);
    directed_ops = draw_cmds.size();

    // Random part. Most drawing stays on or just past the screen, with a
    // share spread over the full coordinate range; about half of all draws
    // are followed by a read of a byte near where they drew so that changes
    // are seen. Whole-store clears and fills are kept rare as they are slow.
    while (draw_cmds.size() < directed_ops + RANDOM_TARGET) begin
      roll  = $urandom_range(0, 99);
      px    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SCREEN_W + 7)
                                           : $urandom_range(0, 255);
      py    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SCREEN_H + 7)
                                           : $urandom_range(0, 255);
      bits  = $urandom_range(0, 255);
      nbits = ($urandom_range(0, 99) < 80) ? $urandom_range(1, MAX_BITS)
                                           : $urandom_range(0, 15);
      idx   = $urandom_range(0, STORE_BYTES - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: colour = COLOR_BLACK;
        4, 5, 6, 7: colour = COLOR_WHITE;
        default:    colour = $urandom_range(COLOR_KEEP_LO, COLOR_KEEP_HI);
      endcase
      near_idx = (px % SCREEN_W) + ((py % SCREEN_H) / PAGE_ROWS) * SCREEN_W;
      if (roll < 1) begin
        queue_cmd(FUNC_CLEAR, px, py, colour, bits, nbits, idx);
      end else if (roll < 2) begin
        queue_cmd(FUNC_FILL, px, py, colour, bits, nbits, idx);
      end else if (roll < 3) begin
        f = $urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI);
        queue_cmd(f, px, py, colour, bits, nbits, idx);
      end else if (roll < 63) begin
        f = (roll < 33) ? FUNC_PIXEL : FUNC_BITMAP;
        queue_cmd(f, px, py, colour, bits, nbits, idx);
        if ($urandom_range(0, 1) == 1) begin
          if (f == FUNC_BITMAP) begin
            near_idx = (near_idx + $urandom_range(0, MAX_BITS - 1)) % STORE_BYTES;
          end
          queue_cmd(FUNC_READ, px, py, colour, bits, nbits, near_idx);
        end
      end else begin
        queue_cmd(FUNC_READ, px, py, colour, bits, nbits, idx);
      end
    end
    total_ops = draw_cmds.size();

    // The sender stops and lets the block run dry after the directed part
    // and twice more during the random part.
    for (int k = directed_ops; k < total_ops - TAIL_OPS; k += DRAIN_SPACING) begin
      draw_cmds[k].drain_first = 1'b1;
    end

    worst_cycles += RESET_CYCLES + STORE_BYTES + NUM_HOLDS * LONG_HOLD + SETTLE_CYCLES + 100;
    cycle_limit = 4 * worst_cycles;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in < total_ops || beats_out < beats_in) @(posedge clk);
    // Quiet time to catch any stray result beat.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (outcomes_due.size() != 0) begin
      log_fault($sformatf("%0d predicted results never arrived", outcomes_due.size()));
    end

    $display("Ran %0d operations: %0d clears, %0d fills, %0d pixels, %0d bitmap bytes, %0d reads, %0d unused codes.",
             beats_in, op_tally[FUNC_CLEAR], op_tally[FUNC_FILL], op_tally[FUNC_PIXEL],
             op_tally[FUNC_BITMAP], op_tally[FUNC_READ],
             beats_in - op_tally[FUNC_CLEAR] - op_tally[FUNC_FILL] - op_tally[FUNC_PIXEL]
               - op_tally[FUNC_BITMAP] - op_tally[FUNC_READ]);
    $display("%0d pixels fell outside the screen and were clipped; %0d faults seen.",
             clip_total, fault_count);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mfb_pkg.sv
sv/mfb_ifs.sv
sv/mfb_ram.sv
sv/mono_framebuffer_pixel_blit.sv
dv/tb_mono_framebuffer_pixel_blit.sv
